// ===== hdl/jac_pkg.sv =====
// Package for the joystick axis calibrate core: widths, mode codes,
// register indexes and the sideband record that rides the divider pipeline.
// No dependencies.
`default_nettype none

package jac_pkg;

    // Field widths
    localparam int RAW_W  = 17;  // raw sample and calibration points
    localparam int OUT_W  = 16;  // output range and result
    localparam int DZ_W   = 16;  // deadzone radius
    localparam int CFG_W  = 17;  // widest register
    localparam int IDX_W  = 3;   // register index

    // Datapath widths
    localparam int DIFF_W = RAW_W + 1;         // raw minus one point
    localparam int NUM_W  = RAW_W + 2;         // numerator term, raw minus two points
    localparam int SPAN_W = OUT_W + 1;         // output span
    localparam int DEN_W  = RAW_W;             // positive divisor, below 2**17
    localparam int P1_W   = NUM_W + SPAN_W;    // num * span
    localparam int P2_W   = OUT_W + DEN_W + 1; // base * den
    localparam int SUM_W  = P1_W + 1;          // full numerator
    localparam int QW     = 35;                // numerator magnitude bits, one per divider stage
    localparam int Q_W    = RAW_W + 1;         // saturated quotient
    localparam int RES_W  = Q_W + 1;           // result before clamp

    localparam int CENTER_MARGIN = 10;
    localparam int FULL_SCALE    = 65535;
    localparam int Q_SAT         = 131071;     // beyond this the clamp outcome no longer changes

    // Mode codes
    localparam logic [1:0] MODE_UNCAL    = 2'd0;
    localparam logic [1:0] MODE_STICK    = 2'd1;
    localparam logic [1:0] MODE_THROTTLE = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_AXIS_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_OBSERVED_LOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_OBSERVED_HIGH = 3'd2;
    localparam logic [IDX_W-1:0] REG_CENTER_POINT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEADZONE      = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_LOW       = 3'd5;
    localparam logic [IDX_W-1:0] REG_OUT_HIGH      = 3'd6;
    localparam logic [IDX_W-1:0] REG_INVERT        = 3'd7;

    // Per-item control carried alongside the divider
    typedef struct packed {
        logic                    neg;        // numerator sign
        logic                    use_direct; // result fixed, quotient ignored
        logic signed [OUT_W-1:0] direct_val;
        logic                    post_inv;   // mirror after mapping
        logic                    fault;      // divisor was zero or negative
    } side_t;

endpackage

`default_nettype wire

// ===== hdl/joystick_axis_calibrate_core.sv =====
// Top level of the joystick axis calibrate core: front end, multipliers,
// a one-bit-per-stage restoring divider and the clamp stage.
// Depends on jac_pkg.
`default_nettype none

// Channel      Direction  Payload
// s_axis_*     in         tdata[16:0] raw_value
// m_axis_*     out        tdata[15:0] axis_out, tdata[16] divisor_fault
// cfg_*        in         cfg_index selects register, cfg_data value
//
// One request accepted per cycle while the output is not held; the pipeline has the 35
// divider stages (one quotient bit each) plus front end and clamp stages.
// Reset is synchronous and clears valid bits and configuration registers; no clearing pass.
// The whole pipeline holds while the output register is full and not taken;
// s_axis_tready is then low and nothing is lost or repeated.

module joystick_axis_calibrate_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [jac_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [jac_pkg::CFG_W-1:0]   cfg_data,
    // input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [23:0]                 s_axis_tdata,  // [16:0] raw_value
    // result stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [23:0]                      m_axis_tdata   // [15:0] axis_out, [16] divisor_fault
);
    import jac_pkg::*;

    // Configuration registers
    logic [1:0]              mode_reg;
    logic signed [RAW_W-1:0] obs_low_reg;
    logic signed [RAW_W-1:0] obs_high_reg;
    logic signed [RAW_W-1:0] center_reg;
    logic [DZ_W-1:0]         dz_reg;
    logic signed [OUT_W-1:0] lo_reg;
    logic signed [OUT_W-1:0] hi_reg;
    logic                    inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_UNCAL;
            obs_low_reg  <= '0;
            obs_high_reg <= RAW_W'(65535);
            center_reg   <= RAW_W'(32768);
            dz_reg       <= '0;
            lo_reg       <= OUT_W'(-32768);
            hi_reg       <= OUT_W'(32767);
            inv_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_AXIS_MODE:     mode_reg     <= cfg_data[1:0];
                REG_OBSERVED_LOW:  obs_low_reg  <= cfg_data;
                REG_OBSERVED_HIGH: obs_high_reg <= cfg_data;
                REG_CENTER_POINT:  center_reg   <= cfg_data;
                REG_DEADZONE:      dz_reg       <= cfg_data[DZ_W-1:0];
                REG_OUT_LOW:       lo_reg       <= cfg_data[OUT_W-1:0];
                REG_OUT_HIGH:      hi_reg       <= cfg_data[OUT_W-1:0];
                REG_INVERT:        inv_reg      <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Pipeline advance: everything moves unless the output is held
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Values that depend on configuration only
    logic signed [NUM_W-1:0] obs_low_x, obs_high_x, center_x, dz_x;
    logic signed [NUM_W-1:0] den_l, den_h, den_u;
    logic                    cen_ok;
    logic                    calib;
    logic                    centred;

    always_comb begin
        obs_low_x  = NUM_W'(obs_low_reg);
        obs_high_x = NUM_W'(obs_high_reg);
        center_x   = NUM_W'(center_reg);
        dz_x       = $signed({{(NUM_W-DZ_W){1'b0}}, dz_reg});
        den_l      = center_x - dz_x - obs_low_x;
        den_h      = obs_high_x - center_x - dz_x;
        den_u      = obs_high_x - obs_low_x;
        cen_ok     = center_x > (obs_low_x + NUM_W'(CENTER_MARGIN));
        calib      = (mode_reg == MODE_STICK) || (mode_reg == MODE_THROTTLE);
        centred    = (mode_reg == MODE_STICK) && cen_ok && (dz_reg != '0);
    end

    // Stage 1: distances from the calibration points
    logic                     v1_reg;
    logic signed [RAW_W-1:0]  raw1_reg;
    logic signed [DIFF_W-1:0] dc1_reg, nl1_reg;
    logic signed [NUM_W-1:0]  nh1_reg;
    logic signed [RAW_W-1:0]  raw_in;

    assign raw_in = $signed(s_axis_tdata[RAW_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw1_reg <= raw_in;
            dc1_reg  <= DIFF_W'(raw_in) - DIFF_W'(center_reg);
            nl1_reg  <= DIFF_W'(raw_in) - DIFF_W'(obs_low_reg);
            nh1_reg  <= NUM_W'(raw_in) - center_x - dz_x;
        end
    end

    // Stage 2: pick the mapping segment and its operands
    logic                     v2_reg;
    logic signed [NUM_W-1:0]  num2_reg, num2_next;
    logic signed [SPAN_W-1:0] span2_reg, span2_next;
    logic signed [OUT_W-1:0]  base2_reg, base2_next;
    logic [DEN_W-1:0]         den2_reg, den2_next;
    side_t                    side2_reg, side2_next;
    logic [DIFF_W-1:0]        abs_dc;
    logic signed [SPAN_W-1:0] span_full;

    always_comb begin
        abs_dc     = dc1_reg[DIFF_W-1] ? DIFF_W'(-dc1_reg) : DIFF_W'(dc1_reg);
        span_full  = SPAN_W'(hi_reg) - SPAN_W'(lo_reg);
        num2_next  = NUM_W'(nl1_reg);
        span2_next = span_full;
        base2_next = lo_reg;
        den2_next  = DEN_W'(FULL_SCALE);
        side2_next = '0;
        if (calib) begin
            side2_next.post_inv = inv_reg;
            if (centred) begin
                if (abs_dc < {{(DIFF_W-DZ_W){1'b0}}, dz_reg}) begin
                    // inside the deadzone
                    side2_next.use_direct = 1'b1;
                    side2_next.direct_val = '0;
                end else if (dc1_reg[DIFF_W-1]) begin
                    // left of centre
                    if (den_l <= 0) begin
                        side2_next.fault      = 1'b1;
                        side2_next.use_direct = 1'b1;
                        side2_next.direct_val = lo_reg;
                    end
                    span2_next = -SPAN_W'(lo_reg);
                    den2_next  = den_l[DEN_W-1:0];
                end else begin
                    // right of centre
                    if (den_h <= 0) begin
                        side2_next.fault      = 1'b1;
                        side2_next.use_direct = 1'b1;
                        side2_next.direct_val = '0;
                    end
                    num2_next  = nh1_reg;
                    span2_next = SPAN_W'(hi_reg);
                    base2_next = '0;
                    den2_next  = den_h[DEN_W-1:0];
                end
            end else begin
                // one segment from observed low to observed high
                if (den_u <= 0) begin
                    side2_next.fault      = 1'b1;
                    side2_next.use_direct = 1'b1;
                    side2_next.direct_val = lo_reg;
                end
                den2_next = den_u[DEN_W-1:0];
            end
        end else begin
            // uncalibrated: mirror the sample first
            num2_next = inv_reg ? (NUM_W'(FULL_SCALE) - NUM_W'(raw1_reg)) : NUM_W'(raw1_reg);
        end
        // keep the divider well defined on faults
        if (side2_next.fault) begin
            den2_next = DEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num2_reg  <= num2_next;
            span2_reg <= span2_next;
            base2_reg <= base2_next;
            den2_reg  <= den2_next;
            side2_reg <= side2_next;
        end
    end

    // Stage 3: the two products
    logic                   v3_reg;
    logic signed [P1_W-1:0] p1_reg;
    logic signed [P2_W-1:0] p2_reg;
    logic [DEN_W-1:0]       den3_reg;
    side_t                  side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= P1_W'(num2_reg) * P1_W'(span2_reg);
            p2_reg    <= P2_W'(base2_reg) * $signed({1'b0, den2_reg});
            den3_reg  <= den2_reg;
            side3_reg <= side2_reg;
        end
    end

    // Stage 4: numerator sum, split into sign and magnitude
    logic signed [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0]        n_mag;
    side_t                   side4;

    always_comb begin
        n_sum     = SUM_W'(p1_reg) + SUM_W'(p2_reg);
        n_mag     = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
        side4     = side3_reg;
        side4.neg = n_sum[SUM_W-1];
    end

    // Divider: one quotient bit per stage, dividend bits shift out as
    // quotient bits shift in
    logic             dv_valid_reg [0:QW];
    logic [QW-1:0]    dv_dq_reg    [0:QW];
    logic [DEN_W-1:0] dv_rem_reg   [0:QW];
    logic [DEN_W-1:0] dv_den_reg   [0:QW];
    side_t            dv_side_reg  [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_dq_reg[0]   <= n_mag[QW-1:0];
            dv_rem_reg[0]  <= '0;
            dv_den_reg[0]  <= den3_reg;
            dv_side_reg[0] <= side4;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DEN_W:0]   trial;
        logic [DEN_W+1:0] diff;
        logic             take;

        always_comb begin
            trial = {dv_rem_reg[k], dv_dq_reg[k][QW-1]};
            diff  = {1'b0, trial} - {2'b00, dv_den_reg[k]};
            take  = !diff[DEN_W+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[k+1]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                dv_dq_reg[k+1]   <= {dv_dq_reg[k][QW-2:0], take};
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // Final stage A: sign, saturate, select, mirror
    logic                    vf_reg;
    logic signed [RES_W-1:0] resf_reg, resf_next;
    logic                    faultf_reg;
    logic [Q_W-1:0]          q_sat;
    logic signed [Q_W-1:0]   q_signed;
    logic signed [RES_W-1:0] res_pre;
    side_t                   side_q;

    always_comb begin
        side_q   = dv_side_reg[QW];
        q_sat    = (dv_dq_reg[QW] > QW'(Q_SAT)) ? Q_W'(Q_SAT) : dv_dq_reg[QW][Q_W-1:0];
        q_signed = side_q.neg ? -$signed(q_sat) : $signed(q_sat);
        res_pre  = side_q.use_direct ? RES_W'(side_q.direct_val) : RES_W'(q_signed);
        if (side_q.post_inv) begin
            resf_next = RES_W'(hi_reg) + RES_W'(lo_reg) - res_pre;
        end else begin
            resf_next = res_pre;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= dv_valid_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            resf_reg   <= resf_next;
            faultf_reg <= side_q.fault;
        end
    end

    // Final stage B: clamp, ceiling first, then floor
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_out_reg, m_out_next;
    logic                    m_fault_reg;
    logic signed [RES_W-1:0] clamp_hi;

    always_comb begin
        clamp_hi   = (resf_reg > RES_W'(hi_reg)) ? RES_W'(hi_reg) : resf_reg;
        m_out_next = (clamp_hi < RES_W'(lo_reg)) ? lo_reg : clamp_hi[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_out_reg   <= m_out_next;
            m_fault_reg <= faultf_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, m_fault_reg, m_out_reg};

    // Checks
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid_reg[QW] |-> (dv_rem_reg[QW] < dv_den_reg[QW]))
        else $error("divider remainder not below divisor");

    a_fault_calibrated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_fault_reg) |-> (mode_reg == MODE_STICK || mode_reg == MODE_THROTTLE))
        else $error("divisor fault in uncalibrated mode");

    a_out_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (lo_reg <= hi_reg)) |-> (m_out_reg >= lo_reg && m_out_reg <= hi_reg))
        else $error("result outside output range");

endmodule

`default_nettype wire

// ===== verif/axis_calibrate_checker.sv =====
// Checker for the joystick axis calibrate core: tracks register writes, predicts
// each result from the accepted request and compares it with the result stream.
// Depends on jac_pkg.
`timescale 1ns / 1ps

module axis_calibrate_checker (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [jac_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [jac_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      s_axis_tvalid,
    input  wire logic                      s_axis_tready,
    input  wire logic [23:0]               s_axis_tdata,   // [16:0] raw_value
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    input  wire logic [23:0]               m_axis_tdata,   // [15:0] axis_out, [16] divisor_fault
    output int                             fail_count,
    output int                             pending_count
);
    import jac_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] val;
        logic                    fault;
    } axis_result_t;

    // Local copy of the register file
    logic [1:0]              cfg_mode;
    logic signed [RAW_W-1:0] cfg_obs_low;
    logic signed [RAW_W-1:0] cfg_obs_high;
    logic signed [RAW_W-1:0] cfg_center;
    logic [DZ_W-1:0]         cfg_dz;
    logic signed [OUT_W-1:0] cfg_out_low;
    logic signed [OUT_W-1:0] cfg_out_high;
    logic                    cfg_inv;

    axis_result_t expected_axis_q[$];
    int n_errors = 0;
    int n_queued = 0;

    assign fail_count    = n_errors;
    assign pending_count = n_queued;

    // One line per mismatch
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        n_errors++;
    endtask

    // Calibrated and uncalibrated mapping in 64-bit arithmetic; division truncates toward zero
    function automatic axis_result_t predict_axis(input logic signed [RAW_W-1:0] raw_s);
        longint       raw, lo, hi, olo, ohi, ctr, dz, res, den, dev, rim, n;
        logic         centered;
        axis_result_t r;
        raw = raw_s;
        lo  = cfg_out_low;
        hi  = cfg_out_high;
        olo = cfg_obs_low;
        ohi = cfg_obs_high;
        ctr = cfg_center;
        dz  = cfg_dz;
        r.fault = 1'b0;
        if (cfg_mode == MODE_STICK || cfg_mode == MODE_THROTTLE) begin
            centered = (cfg_mode == MODE_STICK) && (ctr > olo + CENTER_MARGIN) && (dz > 0);
            if (centered) begin
                dev = raw - ctr;
                if (dev < 0) dev = -dev;
                if (dev < dz) begin
                    res = 0;
                end else if (raw < ctr) begin
                    // low side: [obs_low, center - dz] onto [out_low, 0]
                    rim = ctr - dz;
                    den = rim - olo;
                    if (den <= 0) begin
                        r.fault = 1'b1;
                        res = lo;
                    end else begin
                        res = ((raw - olo) * (-lo) + lo * den) / den;
                    end
                end else begin
                    // high side: [center + dz, obs_high] onto [0, out_high]
                    rim = ctr + dz;
                    den = ohi - rim;
                    if (den <= 0) begin
                        r.fault = 1'b1;
                        res = 0;
                    end else begin
                        res = ((raw - rim) * hi) / den;
                    end
                end
            end else begin
                den = ohi - olo;
                if (den <= 0) begin
                    r.fault = 1'b1;
                    res = lo;
                end else begin
                    res = ((raw - olo) * (hi - lo) + lo * den) / den;
                end
            end
            if (cfg_inv) res = hi + lo - res;
        end else begin
            // uncalibrated; the spare mode code lands here too
            n   = cfg_inv ? FULL_SCALE - raw : raw;
            res = (n * (hi - lo) + lo * FULL_SCALE) / FULL_SCALE;
        end
        // ceiling first, then floor: a crossed range ends at out_low
        if (res > hi) res = hi;
        if (res < lo) res = lo;
        r.val = res[OUT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        axis_result_t got, want;
        if (!aresetn) begin
            cfg_mode     = MODE_UNCAL;
            cfg_obs_low  = '0;
            cfg_obs_high = 17'sd65535;
            cfg_center   = 17'sd32768;
            cfg_dz       = '0;
            cfg_out_low  = -16'sd32768;
            cfg_out_high = 16'sd32767;
            cfg_inv      = 1'b0;
            expected_axis_q.delete();
        end else begin
            // accepted request -> one expected result, appended at the tail
            if (s_axis_tvalid && s_axis_tready)
                expected_axis_q.insert(expected_axis_q.size(),
                                       predict_axis(s_axis_tdata[RAW_W-1:0]));

            // accepted result -> compare with oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got.val   = m_axis_tdata[OUT_W-1:0];
                got.fault = m_axis_tdata[OUT_W];
                if (expected_axis_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d fault %0b with nothing expected",
                                              got.val, got.fault));
                end else begin
                    want = expected_axis_q.pop_front();
                    if (got.val !== want.val)
                        report_mismatch($sformatf("axis_out %0d, expected %0d",
                                                  got.val, want.val));
                    if (got.fault !== want.fault)
                        report_mismatch($sformatf("divisor_fault %0b, expected %0b",
                                                  got.fault, want.fault));
                end
            end

            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_AXIS_MODE:     cfg_mode     = cfg_data[1:0];
                    REG_OBSERVED_LOW:  cfg_obs_low  = cfg_data[RAW_W-1:0];
                    REG_OBSERVED_HIGH: cfg_obs_high = cfg_data[RAW_W-1:0];
                    REG_CENTER_POINT:  cfg_center   = cfg_data[RAW_W-1:0];
                    REG_DEADZONE:      cfg_dz       = cfg_data[DZ_W-1:0];
                    REG_OUT_LOW:       cfg_out_low  = cfg_data[OUT_W-1:0];
                    REG_OUT_HIGH:      cfg_out_high = cfg_data[OUT_W-1:0];
                    REG_INVERT:        cfg_inv      = cfg_data[0];
                    default: ;
                endcase
            end
        end
        n_queued <= expected_axis_q.size();
    end

endmodule

// ===== verif/tb_joystick_axis_calibrate_core.sv =====
// Testbench top for the joystick axis calibrate core: clock, reset, register
// setup, request and result stream drivers, and the verdict.
// Depends on jac_pkg, joystick_axis_calibrate_core and axis_calibrate_checker.
`timescale 1ns / 1ps

module tb_joystick_axis_calibrate_core;
    import jac_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         ITEMS_PHASE = 550;
    localparam int         HOLD_CYCLES = 150;
    localparam int         HOLD_AT_A   = 200;
    localparam int         HOLD_AT_B   = 1300;
    localparam int         TAIL_CYCLES = 60;

    typedef struct {
        logic [1:0]              mode;
        logic signed [RAW_W-1:0] obs_low;
        logic signed [RAW_W-1:0] obs_high;
        logic signed [RAW_W-1:0] center;
        logic [DZ_W-1:0]         dz;
        logic signed [OUT_W-1:0] out_low;
        logic signed [OUT_W-1:0] out_high;
        logic                    inv;
    } axis_cfg_t;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_W-1:0]   cfg_data      = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;

    int fail_count;
    int pending_count;
    int src_idle_pct  = 34;
    int sink_idle_pct = 51;

    joystick_axis_calibrate_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    axis_calibrate_checker u_axis_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("[joystick_axis_calibrate_core] ERROR");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs that back the pipe up
    initial begin
        int hold_left;
        int results_seen;
        hold_left    = 0;
        results_seen = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    function automatic longint rnd(input longint a, input longint b);
        return a + longint'($urandom_range(0, int'(b - a)));
    endfunction

    // Mostly random, with the range ends picked often
    function automatic longint pick_val(input longint a, input longint b);
        case (rnd(0, 7))
            0:       return a;
            1:       return b;
            default: return rnd(a, b);
        endcase
    endfunction

    function automatic axis_cfg_t make_cfg(input logic [1:0] mode, input longint olo,
                                           input longint ohi, input longint ctr,
                                           input longint dz, input longint out_lo,
                                           input longint out_hi, input logic inv);
        axis_cfg_t c;
        c.mode     = mode;
        c.obs_low  = 17'(olo);
        c.obs_high = 17'(ohi);
        c.center   = 17'(ctr);
        c.dz       = 16'(dz);
        c.out_low  = 16'(out_lo);
        c.out_high = 16'(out_hi);
        c.inv      = inv;
        return c;
    endfunction

    // Usually a plausible calibration, sometimes anything at all
    function automatic axis_cfg_t random_cfg();
        longint olo, span, ohi, ctr;
        logic [1:0] mode;
        logic inv;
        mode = 2'($urandom_range(0, 3));
        inv  = 1'($urandom_range(0, 1));
        if (rnd(0, 3) != 0) begin
            olo  = rnd(-65536, 32768);
            span = rnd(20, 65535 - olo);
            ohi  = olo + span;
            ctr  = rnd(olo + 11, ohi);
            return make_cfg(mode, olo, ohi, ctr, (rnd(0, 5) == 0) ? 0 : rnd(0, span / 4),
                            rnd(-32768, 0), rnd(0, 32767), inv);
        end
        return make_cfg(mode, pick_val(-65536, 65535), pick_val(-65536, 65535),
                        pick_val(-65536, 65535), pick_val(0, 65535),
                        pick_val(-32768, 32767), pick_val(-32768, 32767), inv);
    endfunction

    // Samples clustered on the calibration points, some anywhere
    function automatic logic [RAW_W-1:0] random_raw(input axis_cfg_t c);
        longint lo, hi, ctr, dz, v;
        lo  = c.obs_low;
        hi  = c.obs_high;
        ctr = c.center;
        dz  = c.dz;
        case (rnd(0, 9))
            0, 1:    v = rnd(-65536, 65535);
            2:       v = rnd(0, 1) ? -65536 : 65535;
            3, 4, 5: v = (lo <= hi) ? rnd(lo, hi) : rnd(hi, lo);
            6, 7, 8: v = ctr + rnd(-dz - 3, dz + 3);
            default: v = (rnd(0, 1) ? lo : hi) + rnd(-2, 2);
        endcase
        if (v < -65536) v = -65536;
        if (v > 65535)  v = 65535;
        return v[RAW_W-1:0];
    endfunction

    // One request; valid stays up across back-to-back requests
    task automatic send_raw(input logic [RAW_W-1:0] raw);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, raw};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Every request yields a result, so an empty scoreboard means an idle core
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic load_config(input axis_cfg_t c);
        write_reg(REG_AXIS_MODE, 17'(c.mode));
        write_reg(REG_OBSERVED_LOW, c.obs_low);
        write_reg(REG_OBSERVED_HIGH, c.obs_high);
        write_reg(REG_CENTER_POINT, c.center);
        write_reg(REG_DEADZONE, 17'(c.dz));
        write_reg(REG_OUT_LOW, 17'(c.out_low));
        write_reg(REG_OUT_HIGH, 17'(c.out_high));
        write_reg(REG_INVERT, 17'(c.inv));
        cfg_we <= 1'b0;
    endtask

    initial begin
        axis_cfg_t c;
        int n_left;
        int blk;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset calibration: uncalibrated, full output span
        send_raw(-65536);
        send_raw(65535);
        send_raw(0);
        send_raw(32768);
        send_raw(-1);
        drain();

        // Centered stick: deadzone, deadzone edge, both sides, both ends
        load_config(make_cfg(MODE_STICK, 0, 65535, 32768, 1000, -32768, 32767, 1'b0));
        send_raw(32768);
        send_raw(31768);
        send_raw(0);
        send_raw(65535);
        send_raw(33768);
        drain();

        // Centered with both sides collapsed: zero or negative divisors, inverted
        load_config(make_cfg(MODE_STICK, -100, 50, 40, 200, -32768, 32767, 1'b1));
        send_raw(-65536);
        send_raw(300);
        send_raw(0);
        drain();

        // Throttle with empty calibration span and a crossed output range
        load_config(make_cfg(MODE_THROTTLE, 500, 500, 0, 65535, 100, -100, 1'b1));
        send_raw(0);
        send_raw(65535);
        drain();

        // Spare mode code behaves as uncalibrated, inverted before scaling
        load_config(make_cfg(MODE_SPARE, 0, 65535, 32768, 0, -32768, 32767, 1'b1));
        send_raw(-65536);
        send_raw(65535);
        send_raw(0);
        drain();

        // Stick whose center is within the margin falls back to linear mapping
        load_config(make_cfg(MODE_STICK, -65536, 65535, -65526, 65535, -32768, 32767, 1'b0));
        send_raw(-65536);
        send_raw(65535);
        send_raw(12345);
        drain();

        // Random calibrations and samples under three idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle_pct = 34; sink_idle_pct = 51; end
                1: begin src_idle_pct = 51; sink_idle_pct = 34; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            n_left = ITEMS_PHASE;
            while (n_left > 0) begin
                drain();
                c = random_cfg();
                load_config(c);
                blk = $urandom_range(20, 80);
                if (blk > n_left) blk = n_left;
                repeat (blk) send_raw(random_raw(c));
                n_left -= blk;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[joystick_axis_calibrate_core] OK");
        else
            $display("[joystick_axis_calibrate_core] ERROR");
        $finish;
    end

endmodule
